@@ rtl/core/frt_pkg.sv @@
// shared types, constants and codes for the fragment reassembly table
package frt_pkg;

  localparam int unsigned SlotsDefault = 8;
  localparam logic [7:0] HeadLenReset = 8'd8;

  // result status codes
  localparam logic [1:0] StatPartial    = 2'd0;
  localparam logic [1:0] StatComplete   = 2'd1;
  localparam logic [1:0] StatBadTotal   = 2'd2;
  localparam logic [1:0] StatOutOfOrder = 2'd3;

  // fragment header as held during a lookup
  typedef struct packed {
    logic [7:0]  message_id;
    logic [15:0] source_address;
    logic [7:0]  part_index;
    logic [7:0]  total_parts;
    logic [7:0]  payload_size;
  } hdr_t;

  // per-slot reassembly context
  typedef struct packed {
    logic [7:0]  message_id;
    logic [15:0] source_address;
    logic [7:0]  total_parts;
    logic [7:0]  parts_seen;
    logic [15:0] bytes_seen;
  } ctx_t;

endpackage

@@ rtl/core/frt_hdr_if.sv @@
// fragment header request channel
interface frt_hdr_if;
  logic        valid;
  logic        ready;
  logic [7:0]  message_id;
  logic [15:0] source_address;
  logic [7:0]  part_index;
  logic [7:0]  total_parts;
  logic [7:0]  payload_size;

  modport source (
    output valid, message_id, source_address, part_index, total_parts, payload_size,
    input  ready
  );
  modport sink (
    input  valid, message_id, source_address, part_index, total_parts, payload_size,
    output ready
  );
endinterface

@@ rtl/core/frt_res_if.sv @@
// lookup result channel
interface frt_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  slot;
  logic [15:0] write_offset;
  logic [7:0]  assembled_length;

  modport source (
    output valid, status, slot, write_offset, assembled_length,
    input  ready
  );
  modport sink (
    input  valid, status, slot, write_offset, assembled_length,
    output ready
  );
endinterface

@@ rtl/core/frt_cfg_if.sv @@
// head length register write channel
interface frt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

@@ rtl/core/fragment_reassembly_table.sv @@
// fragment reassembly table: slot lookup sequencer, context update and result register
//
// usage
//   hdr_i takes one fragment header per request; ready is high only while the
//   sequencer is idle. res_o returns exactly one result per header: status,
//   slot, payload write offset and (on completion) the assembled length.
//   cfg_i writes the head length register; it is always ready and should only
//   be written while no header is in flight.
// sequencing
//   an accepted header starts a scan that reads the slots in order from slot 0;
//   a hit ends the scan and a miss scans every slot, then the update step loads
//   the result. hdr_i is ready again the cycle after the result loads. one compare
//   unit matches one slot a cycle, in the cycle after that slot's read.
// reset
//   all slots free, eviction pointer at zero, head length 8. the context memory
//   is not cleared; busy bits gate every read of it.
// stalls
//   the result sits in an output register; the next header is taken while it
//   waits. if the receiver still holds the old result when the next one is
//   ready, the sequencer waits in its update step until the register frees.
module fragment_reassembly_table #(
  parameter int unsigned SLOTS = frt_pkg::SlotsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  frt_hdr_if.sink      hdr_i,
  frt_res_if.source    res_o,
  frt_cfg_if.sink      cfg_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  // sequencer states
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StUpdate = 2'd2;

  logic [1:0]       state_q, state_d;
  frt_pkg::hdr_t    hdr_q, hdr_d;
  logic [IdxW-1:0]  rd_addr_q, rd_addr_d;
  logic             issue_done_q, issue_done_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             free_vld_q, free_vld_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  frt_pkg::ctx_t    ctx_q, ctx_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic [SLOTS-1:0] busy_q, busy_d;
  logic [7:0]       head_len_q;

  logic             out_vld_q, out_vld_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [2:0]       out_slot_q, out_slot_d;
  logic [15:0]      out_offset_q, out_offset_d;
  logic [7:0]       out_length_q, out_length_d;

  frt_pkg::ctx_t    rd_data;
  frt_pkg::ctx_t    wr_data;
  logic             wr_en;
  logic             hit;
  logic             load;
  logic             hdr_take;
  logic [IdxW-1:0]  ptr_next;

  // update step datapath
  logic             bad_total;
  logic             out_of_order;
  logic             last_part;
  logic [15:0]      new_bytes;
  logic [8:0]       part_plus;

  frt_ctx_ram #(
    .Slots (SLOTS)
  ) u_ctx_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot_q),
    .wdata_i (wr_data),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  assign hdr_i.ready = (state_q == StIdle);
  assign hdr_take    = hdr_i.valid && hdr_i.ready;
  assign cfg_i.ready = 1'b1;

  // shared match unit: one slot per cycle
  assign hit = pend_q && busy_q[cmp_idx_q]
               && (rd_data.message_id == hdr_q.message_id)
               && (rd_data.source_address == hdr_q.source_address);

  // round robin pointer, pre-incremented on eviction
  assign ptr_next = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;

  // context update checks
  assign bad_total    = (hdr_q.total_parts != ctx_q.total_parts);
  assign out_of_order = (hdr_q.part_index != ctx_q.parts_seen);
  assign new_bytes    = ctx_q.bytes_seen + {8'd0, hdr_q.payload_size};
  assign part_plus    = {1'b0, hdr_q.part_index} + 9'd1;
  assign last_part    = (hdr_q.total_parts != 8'd0)
                        && (part_plus == {1'b0, hdr_q.total_parts});

  // result register frees or is being taken
  assign load  = (state_q == StUpdate) && (!out_vld_q || res_o.ready);
  assign wr_en = load;

  always_comb begin
    wr_data            = ctx_q;
    wr_data.parts_seen = ctx_q.parts_seen + 8'd1;
    wr_data.bytes_seen = new_bytes;
  end

  always_comb begin
    state_d      = state_q;
    hdr_d        = hdr_q;
    rd_addr_d    = rd_addr_q;
    issue_done_d = issue_done_q;
    pend_d       = 1'b0;
    cmp_idx_d    = rd_addr_q;
    free_vld_d   = free_vld_q;
    free_idx_d   = free_idx_q;
    slot_d       = slot_q;
    ctx_d        = ctx_q;
    ptr_d        = ptr_q;
    busy_d       = busy_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_offset_d = out_offset_q;
    out_length_d = out_length_q;

    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (hdr_take) begin
          hdr_d.message_id     = hdr_i.message_id;
          hdr_d.source_address = hdr_i.source_address;
          hdr_d.part_index     = hdr_i.part_index;
          hdr_d.total_parts    = hdr_i.total_parts;
          hdr_d.payload_size   = hdr_i.payload_size;
          rd_addr_d            = '0;
          issue_done_d         = 1'b0;
          free_vld_d           = 1'b0;
          state_d              = StScan;
        end
      end
      StScan: begin
        // read issue side
        if (!issue_done_q) begin
          pend_d = 1'b1;
          if (rd_addr_q == LastIdx) begin
            issue_done_d = 1'b1;
          end else begin
            rd_addr_d = rd_addr_q + 1'b1;
          end
        end
        // compare side
        if (pend_q) begin
          if (!busy_q[cmp_idx_q] && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (hit) begin
            slot_d  = cmp_idx_q;
            ctx_d   = rd_data;
            pend_d  = 1'b0;
            state_d = StUpdate;
          end else if (cmp_idx_q == LastIdx) begin
            // no match: lowest free slot, else evict
            ctx_d.message_id     = hdr_q.message_id;
            ctx_d.source_address = hdr_q.source_address;
            ctx_d.total_parts    = hdr_q.total_parts;
            ctx_d.parts_seen     = 8'd0;
            ctx_d.bytes_seen     = 16'd0;
            if (free_vld_q) begin
              slot_d = free_idx_q;
            end else if (!busy_q[cmp_idx_q]) begin
              slot_d = cmp_idx_q;
            end else begin
              ptr_d  = ptr_next;
              slot_d = ptr_next;
            end
            state_d = StUpdate;
          end
        end
      end
      StUpdate: begin
        if (load) begin
          out_vld_d  = 1'b1;
          out_slot_d = 3'(slot_q);
          if (bad_total) begin
            out_status_d   = frt_pkg::StatBadTotal;
            out_offset_d   = 16'd0;
            out_length_d   = 8'd0;
            busy_d[slot_q] = 1'b0;
          end else if (out_of_order) begin
            out_status_d   = frt_pkg::StatOutOfOrder;
            out_offset_d   = 16'd0;
            out_length_d   = 8'd0;
            busy_d[slot_q] = 1'b0;
          end else if (last_part) begin
            out_status_d   = frt_pkg::StatComplete;
            out_offset_d   = ctx_q.bytes_seen;
            out_length_d   = new_bytes[7:0] + head_len_q;
            busy_d[slot_q] = 1'b0;
          end else begin
            out_status_d   = frt_pkg::StatPartial;
            out_offset_d   = ctx_q.bytes_seen;
            out_length_d   = 8'd0;
            busy_d[slot_q] = 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      free_vld_q   <= 1'b0;
      ptr_q        <= '0;
      busy_q       <= '0;
      head_len_q   <= frt_pkg::HeadLenReset;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_done_q <= issue_done_d;
      pend_q       <= pend_d;
      free_vld_q   <= free_vld_d;
      ptr_q        <= ptr_d;
      busy_q       <= busy_d;
      out_vld_q    <= out_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        head_len_q <= cfg_i.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hdr_q        <= hdr_d;
    rd_addr_q    <= rd_addr_d;
    cmp_idx_q    <= cmp_idx_d;
    free_idx_q   <= free_idx_d;
    slot_q       <= slot_d;
    ctx_q        <= ctx_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_offset_q <= out_offset_d;
    out_length_q <= out_length_d;
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.status           = out_status_q;
  assign res_o.slot             = out_slot_q;
  assign res_o.write_offset     = out_offset_q;
  assign res_o.assembled_length = out_length_q;

endmodule

@@ rtl/core/frt_ctx_ram.sv @@
// slot context memory, one write and one registered read port
module frt_ctx_ram #(
  parameter int unsigned Slots = frt_pkg::SlotsDefault,
  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  frt_pkg::ctx_t    wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output frt_pkg::ctx_t    rdata_o
);

  frt_pkg::ctx_t mem_q [Slots];
  frt_pkg::ctx_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sim/tb_fragment_reassembly_table.sv @@
// self-checking regression for the fragment reassembly table: directed cases, random traffic
`timescale 1ns / 100ps

module tb_fragment_reassembly_table;

  localparam int unsigned SLOTS       = frt_pkg::SlotsDefault;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned REPORT_MAX  = 10;

  // one lookup outcome as the block reports it
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [15:0] write_offset;
    logic [7:0]  assembled_length;
  } verdict_t;

  // a message the random generator is walking through in order
  typedef struct {
    logic [7:0]  message_id;
    logic [15:0] source_address;
    logic [7:0]  total_parts;
    logic [7:0]  next_part;
  } stream_t;

  logic clk = 1'b0;
  logic rst_n;

  frt_hdr_if hdr_if ();
  frt_res_if res_if ();
  frt_cfg_if cfg_if ();

  fragment_reassembly_table #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .hdr_i (hdr_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always #6 clk = ~clk;

  // context table mirror
  frt_pkg::ctx_t ctx_mirror[SLOTS];
  bit            ctx_live[SLOTS];
  int unsigned   evict_ptr;
  logic [7:0]    head_len_mirror = frt_pkg::HeadLenReset;

  verdict_t    verdicts_due[$];

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned cycle_count     = 0;
  int unsigned fail_count      = 0;
  int unsigned evictions       = 0;
  int unsigned results_checked = 0;
  int unsigned status_tally[4];

  // slot lookup, allocation and context update for one header
  function automatic verdict_t reassemble_step(frt_pkg::hdr_t h);
    int unsigned s;
    bit          hit;
    bit          free_found;
    verdict_t    v;
    hit        = 1'b0;
    free_found = 1'b0;
    s          = 0;
    v          = '0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (!hit && ctx_live[i] && ctx_mirror[i].message_id == h.message_id &&
          ctx_mirror[i].source_address == h.source_address) begin
        hit = 1'b1;
        s   = i;
      end
    end
    if (!hit) begin
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (!free_found && !ctx_live[i]) begin
          free_found = 1'b1;
          s          = i;
        end
      end
      // table full: pointer moves first, then its slot is taken
      if (!free_found) begin
        evict_ptr = (evict_ptr + 1) % SLOTS;
        s         = evict_ptr;
        evictions++;
      end
      ctx_live[s]                  = 1'b1;
      ctx_mirror[s].message_id     = h.message_id;
      ctx_mirror[s].source_address = h.source_address;
      ctx_mirror[s].total_parts    = h.total_parts;
      ctx_mirror[s].parts_seen     = '0;
      ctx_mirror[s].bytes_seen     = '0;
    end

    if (h.total_parts != ctx_mirror[s].total_parts) begin
      ctx_live[s] = 1'b0;
      v.status    = frt_pkg::StatBadTotal;
    end else if (h.part_index != ctx_mirror[s].parts_seen) begin
      ctx_live[s] = 1'b0;
      v.status    = frt_pkg::StatOutOfOrder;
    end else begin
      v.write_offset           = ctx_mirror[s].bytes_seen;
      ctx_mirror[s].bytes_seen = ctx_mirror[s].bytes_seen + 16'(h.payload_size);
      ctx_mirror[s].parts_seen = ctx_mirror[s].parts_seen + 8'd1;
      // zero total never completes
      if (h.total_parts != 8'd0 &&
          {1'b0, h.part_index} + 9'd1 == {1'b0, h.total_parts}) begin
        v.assembled_length = ctx_mirror[s].bytes_seen[7:0] + head_len_mirror;
        ctx_live[s]        = 1'b0;
        v.status           = frt_pkg::StatComplete;
      end else begin
        v.status = frt_pkg::StatPartial;
      end
    end
    v.slot = s[2:0];
    return v;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%s", msg);
  endfunction

  function automatic frt_pkg::hdr_t frag(logic [7:0] id, logic [15:0] src, logic [7:0] part,
                                         logic [7:0] total, logic [7:0] size);
    frt_pkg::hdr_t h;
    h.message_id     = id;
    h.source_address = src;
    h.part_index     = part;
    h.total_parts    = total;
    h.payload_size   = size;
    return h;
  endfunction

  // every accepted header gets its verdict predicted on the spot
  always @(posedge clk) begin
    if (rst_n && hdr_if.valid && hdr_if.ready) begin
      verdicts_due.push_back(reassemble_step(frt_pkg::hdr_t'({hdr_if.message_id,
                                                              hdr_if.source_address,
                                                              hdr_if.part_index,
                                                              hdr_if.total_parts,
                                                              hdr_if.payload_size})));
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) head_len_mirror = cfg_if.data;
  end

  // compare each returned result with the oldest prediction
  always @(posedge clk) begin : result_check
    verdict_t want;
    verdict_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = {res_if.status, res_if.slot, res_if.write_offset, res_if.assembled_length};
      results_checked++;
      status_tally[got.status]++;
      if (verdicts_due.size() == 0) begin
        note_failure($sformatf("result with nothing pending: status %0d slot %0d off %0d len %0d",
                               got.status, got.slot, got.write_offset, got.assembled_length));
      end else begin
        want = verdicts_due.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.write_offset !== want.write_offset ||
            got.assembled_length !== want.assembled_length) begin
          note_failure($sformatf(
            "mismatch: exp status %0d slot %0d off %0d len %0d, got %0d %0d %0d %0d",
            want.status, want.slot, want.write_offset, want.assembled_length,
            got.status, got.slot, got.write_offset, got.assembled_length));
        end
      end
    end
  end

  // result side: random stalls, or a long counted hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        res_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, verdicts_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid is left high after acceptance; the next call or a drain decides its fate
  task automatic send_header(frt_pkg::hdr_t h);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      hdr_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    hdr_if.valid          <= 1'b1;
    hdr_if.message_id     <= h.message_id;
    hdr_if.source_address <= h.source_address;
    hdr_if.part_index     <= h.part_index;
    hdr_if.total_parts    <= h.total_parts;
    hdr_if.payload_size   <= h.payload_size;
    do @(posedge clk); while (!hdr_if.ready);
  endtask

  task automatic await_all_verdicts();
    hdr_if.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_head_length(logic [7:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // one-part messages at the field extremes, length wraps past 255
  task automatic test_single_part();
    send_header(frag(8'hFF, 16'hFFFF, 8'd0, 8'd1, 8'hFF));
    send_header(frag(8'h00, 16'h0000, 8'd0, 8'd1, 8'h00));
  endtask

  task automatic test_in_order_message();
    send_header(frag(8'h01, 16'h1234, 8'd0, 8'd3, 8'd100));
    send_header(frag(8'h01, 16'h1234, 8'd1, 8'd3, 8'd60));
    send_header(frag(8'h01, 16'h1234, 8'd2, 8'd3, 8'd7));
  endtask

  task automatic test_total_mismatch();
    send_header(frag(8'h02, 16'h0002, 8'd0, 8'd4, 8'd10));
    send_header(frag(8'h02, 16'h0002, 8'd1, 8'd5, 8'd10));
  endtask

  // a skipped part, then a message that opens past part zero
  task automatic test_out_of_order();
    send_header(frag(8'h03, 16'h0003, 8'd0, 8'd4, 8'd20));
    send_header(frag(8'h03, 16'h0003, 8'd2, 8'd4, 8'd20));
    send_header(frag(8'h04, 16'h0004, 8'd3, 8'd4, 8'd20));
  endtask

  // zero total stays partial; a bad total frees the slot again
  task automatic test_zero_total();
    send_header(frag(8'h05, 16'h0005, 8'd0, 8'd0, 8'd30));
    send_header(frag(8'h05, 16'h0005, 8'd1, 8'd0, 8'd31));
    send_header(frag(8'h05, 16'h0005, 8'd2, 8'd0, 8'd32));
    send_header(frag(8'h05, 16'h0005, 8'd3, 8'd5, 8'd33));
  endtask

  // fill every slot, then three newcomers evict slots 1..3; an evicted message's
  // next part lands in a fresh slot and is dropped out of order
  task automatic test_eviction();
    for (int k = 0; k < SLOTS; k++) send_header(frag(8'h10 + 8'(k), 16'h0100, 8'd0, 8'd3, 8'd9));
    for (int k = 0; k < 3; k++) send_header(frag(8'h20 + 8'(k), 16'h0100, 8'd0, 8'd2, 8'd9));
    send_header(frag(8'h11, 16'h0100, 8'd1, 8'd3, 8'd9));
  endtask

  // 255-part message, then a zero-total stream long enough to wrap both counters
  task automatic test_counter_wrap();
    for (int k = 0; k < 255; k++) send_header(frag(8'h30, 16'hABCD, 8'(k), 8'd255, 8'hFF));
    for (int k = 0; k < 300; k++) send_header(frag(8'h31, 16'h5A5A, 8'(k), 8'd0, 8'hFF));
    send_header(frag(8'h31, 16'h5A5A, 8'd99, 8'd0, 8'h01));
  endtask

  // receiver holds off while headers keep coming, so the block backs up
  task automatic test_result_backlog();
    hold_off_cycles = 150;
    for (int k = 0; k < 16; k++) send_header(frag(8'(k), 16'h7000, 8'd0, 8'd1, 8'($urandom)));
    await_all_verdicts();
  endtask

  // sender waits for every result before going on
  task automatic test_sender_pause();
    for (int k = 0; k < 6; k++) send_header(frag(8'h40, 16'h0040, 8'(k), 8'd12, 8'($urandom)));
    await_all_verdicts();
    for (int k = 6; k < 12; k++) send_header(frag(8'h40, 16'h0040, 8'(k), 8'd12, 8'($urandom)));
    await_all_verdicts();
  endtask

  // mostly in-order messages with random content, plus corrupted and stray headers
  task automatic run_random_traffic(int unsigned count, int unsigned idle_pct,
                                    int unsigned stall_pct);
    stream_t       pool[$];
    stream_t       st;
    frt_pkg::hdr_t h;
    int unsigned   idx;
    int unsigned   roll;
    bit            closes;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      // keep more streams open than slots now and then, to force evictions
      if (pool.size() < 4 || (pool.size() < 11 && $urandom_range(99) < 10)) begin
        st.message_id     = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
        st.source_address = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
        roll              = $urandom_range(99);
        st.total_parts    = (roll < 80) ? 8'($urandom_range(6, 1)) :
                            (roll < 95) ? 8'($urandom_range(40, 7)) : 8'd0;
        st.next_part      = '0;
        pool.push_back(st);
      end
      idx    = $urandom_range(pool.size() - 1);
      st     = pool[idx];
      h      = frag(st.message_id, st.source_address, st.next_part, st.total_parts,
                    8'($urandom));
      roll   = $urandom_range(99);
      closes = 1'b0;
      if (roll < 4) begin
        h.total_parts = 8'($urandom);
        closes        = 1'b1;
      end else if (roll < 8) begin
        h.part_index = 8'($urandom);
        closes       = 1'b1;
      end else if (roll < 12) begin
        h = frag(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        st.next_part++;
        closes = (st.total_parts != 0 && st.next_part == st.total_parts) ||
                 (st.total_parts == 0 && $urandom_range(15) == 0);
      end
      if (closes) pool.delete(idx);
      else pool[idx] = st;
      send_header(h);
    end
    await_all_verdicts();
  endtask

  initial begin : regression
    hdr_if.valid          = 1'b0;
    hdr_if.message_id     = '0;
    hdr_if.source_address = '0;
    hdr_if.part_index     = '0;
    hdr_if.total_parts    = '0;
    hdr_if.payload_size   = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.data           = '0;
    res_if.ready          = 1'b0;
    rst_n                 = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed cases run with the reset head length
    test_single_part();
    test_in_order_message();
    test_total_mismatch();
    test_out_of_order();
    test_zero_total();
    test_eviction();
    await_all_verdicts();

    write_head_length(8'hFF);
    test_counter_wrap();
    await_all_verdicts();
    test_result_backlog();
    test_sender_pause();

    write_head_length(8'h00);
    run_random_traffic(175, 0, 0);
    write_head_length(8'hFF);
    run_random_traffic(175, 67, 0);
    write_head_length(8'($urandom));
    run_random_traffic(175, 0, 67);
    write_head_length(frt_pkg::HeadLenReset);
    run_random_traffic(175, 10, 10);

    recv_stall_pct = 0;
    repeat (2 * (SLOTS + 2)) @(posedge clk);
    fail_count += verdicts_due.size();

    $display("%0d results checked: %0d partial, %0d complete, %0d bad total, %0d out of order",
             results_checked, status_tally[frt_pkg::StatPartial],
             status_tally[frt_pkg::StatComplete], status_tally[frt_pkg::StatBadTotal],
             status_tally[frt_pkg::StatOutOfOrder]);
    $display("%0d evictions, counter wrap, head lengths 0/255/random/8, backlog and idle mixes",
             evictions);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
